// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the Fibonacci power unit.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FMP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fmp_pkg.sv =====
// Shared types, constants and the microcode table of the Fibonacci power unit.
// No dependencies; used by the interfaces, the sequencer and the datapath.
`default_nettype none

package fmp_pkg;

    localparam int FIB_W = 16;
    localparam int PC_W  = 4;
    localparam int RED_W = 17;

    localparam logic [FIB_W-1:0] FIB_MODULUS = 16'd46337;
    // Reciprocal for the quotient estimate: floor(2^47 / modulus), below 2^32.
    localparam logic [31:0] FIB_RECIP = 32'((64'd1 << 47) / 64'd46337);

    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_D
    } src_t;

    typedef enum logic [1:0] {
        WB_NONE,
        WB_A,
        WB_BD
    } wb_t;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_SCAN,
        SEQ_TEST,
        SEQ_LOOP,
        SEQ_DONE
    } seq_t;

    typedef struct packed {
        src_t            x_sel;
        src_t            y_sel;
        logic            sum_acc;
        wb_t             wb;
        logic            step_b;
        seq_t            seq;
        logic [PC_W-1:0] target;
    } fmp_ctrl_t;

    typedef struct packed {
        logic init;
        src_t x_sel;
        src_t y_sel;
        logic sum_acc;
        wb_t  wb;
        logic step;
    } fmp_dp_ctrl_t;

    // Microcode addresses.
    localparam logic [PC_W-1:0] ADDR_SCAN   = 4'd0;
    localparam logic [PC_W-1:0] ADDR_TEST   = 4'd1;
    localparam logic [PC_W-1:0] ADDR_MUL_AA = 4'd2;
    localparam logic [PC_W-1:0] ADDR_MUL_BB = 4'd3;
    localparam logic [PC_W-1:0] ADDR_MUL_AB = 4'd4;
    localparam logic [PC_W-1:0] ADDR_MUL_BD = 4'd5;
    localparam logic [PC_W-1:0] ADDR_SUM_2  = 4'd6;
    localparam logic [PC_W-1:0] ADDR_WB_A   = 4'd7;
    localparam logic [PC_W-1:0] ADDR_WAIT   = 4'd8;
    localparam logic [PC_W-1:0] ADDR_WB_B   = 4'd9;
    localparam logic [PC_W-1:0] ADDR_STEP   = 4'd10;
    localparam logic [PC_W-1:0] ADDR_DONE   = 4'd11;

    // The accumulator is B^k = [[a, b], [b, d]]. Squaring needs a*a + b*b
    // and a*b + b*d; each sum passes the pipelined reducer before writeback.
    function automatic fmp_ctrl_t fmp_rom(input logic [PC_W-1:0] addr);
        fmp_ctrl_t cw;
        cw = '{x_sel: SRC_A, y_sel: SRC_A, sum_acc: 1'b0, wb: WB_NONE,
               step_b: 1'b0, seq: SEQ_NEXT, target: ADDR_SCAN};
        case (addr)
            ADDR_SCAN:
            begin
                cw.seq    = SEQ_SCAN;
                cw.target = ADDR_TEST;
            end
            ADDR_TEST:
            begin
                cw.seq    = SEQ_TEST;
                cw.target = ADDR_DONE;
            end
            ADDR_MUL_AA:
            begin
                cw.x_sel = SRC_A;
                cw.y_sel = SRC_A;
            end
            ADDR_MUL_BB:
            begin
                cw.x_sel = SRC_B;
                cw.y_sel = SRC_B;
            end
            ADDR_MUL_AB:
            begin
                cw.x_sel   = SRC_A;
                cw.y_sel   = SRC_B;
                cw.sum_acc = 1'b1;
            end
            ADDR_MUL_BD:
            begin
                cw.x_sel = SRC_B;
                cw.y_sel = SRC_D;
            end
            ADDR_SUM_2:
            begin
                cw.sum_acc = 1'b1;
            end
            ADDR_WB_A:
            begin
                cw.wb = WB_A;
            end
            ADDR_WAIT:
            begin
                cw.seq = SEQ_NEXT;
            end
            ADDR_WB_B:
            begin
                cw.wb = WB_BD;
            end
            ADDR_STEP:
            begin
                cw.step_b = 1'b1;
                cw.seq    = SEQ_LOOP;
                cw.target = ADDR_TEST;
            end
            ADDR_DONE:
            begin
                cw.seq = SEQ_DONE;
            end
            default:
            begin
                cw.seq = SEQ_DONE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fmp_if.sv =====
// Valid/ready channels of the Fibonacci power unit: index items in, results out.
// Depends on fmp_pkg for the result width.
`default_nettype none

interface fmp_index_if #(parameter int INDEX_BITS = 31) ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] index_n;

    modport source (output valid, output index_n, input ready);
    modport sink (input valid, input index_n, output ready);
endinterface

interface fmp_result_if ();
    logic                         valid;
    logic                         ready;
    logic [fmp_pkg::FIB_W-1:0]    fib_value;

    modport source (output valid, output fib_value, input ready);
    modport sink (input valid, input fib_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/fibonacci_matrix_power_mod_unit.sv =====
// The sequencer scans the index one bit per cycle down to its leading one, then
// runs a ten-step square-and-multiply program through one shared multiplier for
// each remaining bit; the result register loads when the program ends.
// Throughput: one item at a time; the next is taken once the result is loaded.
// Reset clears the sequencer and the result valid; the datapath needs none.
`default_nettype none

module fibonacci_matrix_power_mod_unit #(
    parameter int INDEX_BITS = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    fmp_index_if.sink     index_ch,
    fmp_result_if.source  result_ch
);

    fmp_pkg::fmp_dp_ctrl_t     dp_ctrl;
    logic [fmp_pkg::FIB_W-1:0] fib;

    fmp_sequencer #(
        .INDEX_BITS (INDEX_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .index_ch  (index_ch),
        .result_ch (result_ch),
        .dp_ctrl   (dp_ctrl),
        .fib       (fib)
    );

    fmp_datapath u_dp (
        .clk  (clk),
        .ctrl (dp_ctrl),
        .fib  (fib)
    );

endmodule

`default_nettype wire

// ===== hdl/fmp_datapath.sv =====
// Matrix datapath: accumulator entries, one 16x16 multiplier, a sum register
// and a pipelined modular reducer. Depends on fmp_pkg; driven by fmp_sequencer.
`default_nettype none

module fmp_datapath (
    input  logic                      clk,
    input  fmp_pkg::fmp_dp_ctrl_t     ctrl,
    output logic [fmp_pkg::FIB_W-1:0] fib
);

    localparam logic [fmp_pkg::RED_W-1:0] MOD_R = fmp_pkg::RED_W'(fmp_pkg::FIB_MODULUS);

    logic [fmp_pkg::FIB_W-1:0] a_reg;
    logic [fmp_pkg::FIB_W-1:0] b_reg;
    logic [fmp_pkg::FIB_W-1:0] d_reg;
    logic [31:0]               prod_reg;
    logic [31:0]               sum_reg;
    logic [fmp_pkg::RED_W-1:0] s1_reg;
    logic [fmp_pkg::RED_W-1:0] q_reg;
    logic [fmp_pkg::RED_W-1:0] s2_reg;
    logic [fmp_pkg::RED_W-1:0] qm_reg;

    logic [fmp_pkg::FIB_W-1:0] x_op;
    logic [fmp_pkg::FIB_W-1:0] y_op;
    logic [63:0]               est_full;
    logic [32:0]               qm_full;
    logic [fmp_pkg::RED_W-1:0] rem_raw;
    logic [fmp_pkg::FIB_W-1:0] red;

    function automatic logic [fmp_pkg::FIB_W-1:0] add_mod(
        input logic [fmp_pkg::FIB_W-1:0] x,
        input logic [fmp_pkg::FIB_W-1:0] y
    );
        logic [fmp_pkg::RED_W-1:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= MOD_R) begin
            s = s - MOD_R;
        end
        return s[fmp_pkg::FIB_W-1:0];
    endfunction

    always_comb
    begin
        case (ctrl.x_sel)
            fmp_pkg::SRC_A: x_op = a_reg;
            fmp_pkg::SRC_B: x_op = b_reg;
            fmp_pkg::SRC_D: x_op = d_reg;
            default:        x_op = a_reg;
        endcase
        case (ctrl.y_sel)
            fmp_pkg::SRC_A: y_op = a_reg;
            fmp_pkg::SRC_B: y_op = b_reg;
            fmp_pkg::SRC_D: y_op = d_reg;
            default:        y_op = a_reg;
        endcase
    end

    // The quotient estimate is low by at most one, so the remainder lies
    // below twice the modulus and fits in 17 bits.
    assign est_full = 64'(sum_reg) * 64'(fmp_pkg::FIB_RECIP);
    assign qm_full  = 33'(q_reg) * 33'(fmp_pkg::FIB_MODULUS);
    assign rem_raw  = s2_reg - qm_reg;
    assign red      = (rem_raw >= MOD_R) ? fmp_pkg::FIB_W'(rem_raw - MOD_R)
                                         : rem_raw[fmp_pkg::FIB_W-1:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= 32'(x_op) * 32'(y_op);
        sum_reg  <= ctrl.sum_acc ? (sum_reg + prod_reg) : prod_reg;
        q_reg    <= est_full[63:47];
        s1_reg   <= sum_reg[fmp_pkg::RED_W-1:0];
        qm_reg   <= qm_full[fmp_pkg::RED_W-1:0];
        s2_reg   <= s1_reg;

        if (ctrl.init) begin
            a_reg <= '0;
            b_reg <= fmp_pkg::FIB_W'(1);
            d_reg <= fmp_pkg::FIB_W'(1);
        end else if (ctrl.step) begin
            a_reg <= b_reg;
            b_reg <= d_reg;
            d_reg <= add_mod(b_reg, d_reg);
        end else begin
            case (ctrl.wb)
                fmp_pkg::WB_A:
                begin
                    a_reg <= red;
                end
                fmp_pkg::WB_BD:
                begin
                    b_reg <= red;
                    d_reg <= add_mod(a_reg, red);
                end
                default:
                begin
                    a_reg <= a_reg;
                end
            endcase
        end
    end

    assign fib = b_reg;

endmodule

`default_nettype wire

// ===== hdl/fmp_sequencer.sv =====
// Microcode sequencer: step counter, exponent bit scan, channel handshakes and
// the result register. Depends on fmp_pkg, fmp_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fmp_sequencer #(
    parameter int INDEX_BITS = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    fmp_index_if.sink                 index_ch,
    fmp_result_if.source              result_ch,
    output fmp_pkg::fmp_dp_ctrl_t     dp_ctrl,
    input  logic [fmp_pkg::FIB_W-1:0] fib
);

    localparam int CNT_W = $clog2(INDEX_BITS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                      state_reg, state_next;
    logic [fmp_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0]       exp_reg, exp_next;
    logic                        out_valid_reg, out_valid_next;
    logic [fmp_pkg::FIB_W-1:0]   fib_reg, fib_next;

    fmp_pkg::fmp_ctrl_t cw;
    logic               run;
    logic               lead;

    assign cw   = fmp_pkg::fmp_rom(pc_reg);
    assign run  = (state_reg == ST_RUN);
    assign lead = exp_reg[INDEX_BITS-1];

    assign index_ch.ready      = (state_reg == ST_IDLE);
    assign result_ch.valid     = out_valid_reg;
    assign result_ch.fib_value = fib_reg;

    always_comb
    begin
        dp_ctrl.init    = (state_reg == ST_IDLE) && index_ch.valid;
        dp_ctrl.x_sel   = cw.x_sel;
        dp_ctrl.y_sel   = cw.y_sel;
        dp_ctrl.sum_acc = cw.sum_acc;
        dp_ctrl.wb      = run ? cw.wb : fmp_pkg::WB_NONE;
        // Multiply by the base matrix only where the current bit is set.
        dp_ctrl.step    = run && cw.step_b && lead;
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        exp_next       = exp_reg;
        out_valid_next = out_valid_reg;
        fib_next       = fib_reg;

        if (out_valid_reg && result_ch.ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (index_ch.valid) begin
                    state_next = ST_RUN;
                    pc_next    = fmp_pkg::ADDR_SCAN;
                    cnt_next   = CNT_W'(INDEX_BITS);
                    exp_next   = index_ch.index_n;
                end
            end
            ST_RUN:
            begin
                case (cw.seq)
                    fmp_pkg::SEQ_NEXT:
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                    fmp_pkg::SEQ_SCAN:
                    begin
                        // Skip zeros above the leading one; an all-zero index
                        // finishes with the base matrix untouched.
                        exp_next = exp_reg << 1;
                        cnt_next = cnt_reg - 1'b1;
                        if (lead) begin
                            pc_next = cw.target;
                        end else if (cnt_reg == CNT_W'(1)) begin
                            pc_next = fmp_pkg::ADDR_DONE;
                        end
                    end
                    fmp_pkg::SEQ_TEST:
                    begin
                        if (cnt_reg == '0) begin
                            pc_next = cw.target;
                        end else begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    fmp_pkg::SEQ_LOOP:
                    begin
                        exp_next = exp_reg << 1;
                        cnt_next = cnt_reg - 1'b1;
                        pc_next  = cw.target;
                    end
                    fmp_pkg::SEQ_DONE:
                    begin
                        if (!out_valid_reg || result_ch.ready) begin
                            out_valid_next = 1'b1;
                            fib_next       = fib;
                            state_next     = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= fmp_pkg::ADDR_SCAN;
            cnt_reg       <= '0;
            exp_reg       <= '0;
            out_valid_reg <= 1'b0;
            fib_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            exp_reg       <= exp_next;
            out_valid_reg <= out_valid_next;
            fib_reg       <= fib_next;
        end
    end

    `FMP_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !result_ch.valid, "result valid during reset")
    `FMP_ASSERT(a_cnt_range, run |-> cnt_reg <= CNT_W'(INDEX_BITS), "bit count out of range")
    `FMP_ASSERT(a_pc_range, run |-> pc_reg <= fmp_pkg::ADDR_DONE, "step counter past program")
    `FMP_ASSERT(a_out_src, $rose(result_ch.valid) |-> $past(pc_reg) == fmp_pkg::ADDR_DONE, "result loaded outside the final step")

endmodule

`default_nettype wire

// ===== verif/tb_fibonacci_matrix_power_mod_unit.sv =====
// Testbench for fibonacci_matrix_power_mod_unit: drives index items, predicts F(n) mod 46337 (F(1) for a zero index).
// Checks every result in order against the prediction.
// Depends on fmp_pkg, the fmp_index_if/fmp_result_if interfaces and the unit itself.
`timescale 1ns / 100ps

module tb_fibonacci_matrix_power_mod_unit;

    localparam int INDEX_BITS = 31;
    localparam int FIB_W = fmp_pkg::FIB_W;
    localparam longint unsigned FIB_MOD = 46337;
    // Extra clocks to run after the last expected result has been checked.
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 700;

    typedef struct {
        logic [63:0] e00;
        logic [63:0] e01;
        logic [63:0] e10;
        logic [63:0] e11;
    } fib_mat_t;

    typedef struct {
        logic [INDEX_BITS-1:0] index_n;
        logic [FIB_W-1:0]      fib_value;
    } fib_expect_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_BURSTY
    } ready_mode_t;

    logic clk;
    logic rst_n;

    fmp_index_if #(.INDEX_BITS(INDEX_BITS)) index_ch ();
    fmp_result_if result_ch ();

    fibonacci_matrix_power_mod_unit #(
        .INDEX_BITS(INDEX_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .index_ch  (index_ch),
        .result_ch (result_ch)
    );

    logic [INDEX_BITS-1:0] index_stimulus_q[$];
    fib_expect_t           expected_fib_q[$];
    int                    error_count = 0;
    int                    cycle_count = 0;

    // Sender burst state.
    int                    gap_left = 0;
    int                    burst_left = 1;
    logic                  next_valid;
    logic [INDEX_BITS-1:0] next_index;
    fib_expect_t           accepted_fib;

    // Receiver stall state.
    ready_mode_t           ready_mode = READY_ALWAYS;
    int                    mode_left = 0;
    int                    stall_left = 0;
    fib_expect_t           oldest_fib;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic fib_mat_t mat_mul_mod(input fib_mat_t x, input fib_mat_t y);
        fib_mat_t r;
        r.e00 = (x.e00 * y.e00 + x.e01 * y.e10) % FIB_MOD;
        r.e01 = (x.e00 * y.e01 + x.e01 * y.e11) % FIB_MOD;
        r.e10 = (x.e10 * y.e00 + x.e11 * y.e10) % FIB_MOD;
        r.e11 = (x.e10 * y.e01 + x.e11 * y.e11) % FIB_MOD;
        return r;
    endfunction

    // Left-to-right square and multiply; the accumulator starts at the base matrix,
    // so a zero index gives the same value as an index of one.
    function automatic logic [FIB_W-1:0] fib_mod_of(input logic [INDEX_BITS-1:0] n);
        fib_mat_t base;
        fib_mat_t acc;
        int       top;
        base = '{e00: 64'd0, e01: 64'd1, e10: 64'd1, e11: 64'd1};
        acc = base;
        top = -1;
        for (int b = 0; b < INDEX_BITS; b++)
        begin
            if (n[b])
                top = b;
        end
        for (int b = top - 1; b >= 0; b--)
        begin
            acc = mat_mul_mod(acc, acc);
            if (n[b])
                acc = mat_mul_mod(acc, base);
        end
        return acc.e01[FIB_W-1:0];
    endfunction

    task automatic add_index(input logic [63:0] value);
        index_stimulus_q.insert(index_stimulus_q.size(), value[INDEX_BITS-1:0]);
    endtask

    // Sender: holds an item until it is taken, then works through bursts and gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_ch.valid   <= 1'b0;
            index_ch.index_n <= '0;
        end
        else
        begin
            if (index_ch.valid && index_ch.ready)
            begin
                accepted_fib.index_n   = index_ch.index_n;
                accepted_fib.fib_value = fib_mod_of(index_ch.index_n);
                expected_fib_q.insert(expected_fib_q.size(), accepted_fib);
            end
            if (!index_ch.valid || index_ch.ready)
            begin
                next_valid = 1'b0;
                next_index = index_ch.index_n;
                if (gap_left > 0)
                    gap_left--;
                else if (index_stimulus_q.size() > 0)
                begin
                    next_index = index_stimulus_q.pop_front();
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
                index_ch.valid   <= next_valid;
                index_ch.index_n <= next_index;
            end
        end
    end

    // Receiver: checks each result and switches between ready patterns now and then.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_fib_q.size() == 0)
                begin
                    $error("fib_value: no item pending, got %0d", result_ch.fib_value);
                    error_count++;
                end
                else
                begin
                    oldest_fib = expected_fib_q.pop_front();
                    if (result_ch.fib_value !== oldest_fib.fib_value)
                    begin
                        $error("fib_value (index_n %0d): expected %0d, got %0d",
                               oldest_fib.index_n, oldest_fib.fib_value,
                               result_ch.fib_value);
                        error_count++;
                    end
                end
            end

            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(200, 2000);
            end
            else
                mode_left--;

            case (ready_mode)
                READY_ALWAYS:
                begin
                    result_ch.ready <= 1'b1;
                end
                READY_COIN:
                begin
                    result_ch.ready <= 1'($urandom_range(0, 1));
                end
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        result_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        result_ch.ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            stall_left = $urandom_range(1, 8);
                    end
                end
            endcase
        end
    end

    initial
    begin
        logic [63:0] value;
        int          lead;
        int          pick;

        rst_n = 1'b0;

        // Directed: zero and one, small indices, the first wrap past the modulus,
        // leading-bit extremes and alternating bit patterns.
        add_index(0);
        add_index(1);
        add_index(2);
        add_index(3);
        add_index(5);
        add_index(7);
        add_index(10);
        add_index(23);
        add_index(24);
        add_index(25);
        add_index(46337);
        add_index(64'h0000_FFFF);
        add_index(64'h0001_0000);
        add_index(64'h3FFF_FFFF);
        add_index(64'h4000_0000);
        add_index(64'h4000_0001);
        add_index(64'h5555_5555);
        add_index(64'h2AAA_AAAA);
        add_index(64'h7FFF_0000);
        add_index(64'h7FFF_FFFE);
        add_index(64'h7FFF_FFFF);

        // Random: mostly a random leading-bit position with random lower bits,
        // plus small indices and full-width values.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                value = 64'($urandom_range(0, 63));
            else if (pick < 8)
            begin
                lead = $urandom_range(0, INDEX_BITS - 1);
                value = 64'($urandom) & ((64'd1 << (lead + 1)) - 1);
                value = value | (64'd1 << lead);
            end
            else
                value = 64'($urandom);
            add_index(value);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (index_stimulus_q.size() != 0 || index_ch.valid)
            @(posedge clk);
        while (expected_fib_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_fibonacci_matrix_power_mod_unit OK");
        else
            $display("tb_fibonacci_matrix_power_mod_unit NOT OK");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_fibonacci_matrix_power_mod_unit NOT OK");
        $finish;
    end

endmodule
